// ----- sv/lpg_pkg.sv -----
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared constants and types for the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int COLOR_BITS     = 24;

    // Walk direction of the line, settled once per request
    typedef struct packed {
        logic steep;   // major axis is y
        logic down;    // y decreases along the line
    } dir_t;

endpackage

// ----- sv/lpg_step.sv -----
// ----------------------------------------------------------------------------
// lpg_step
// One midpoint step: decide the minor-axis move, update error and position.
// ----------------------------------------------------------------------------
module lpg_step #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
    input  lpg_pkg::dir_t                 dir,
    input  logic signed [COORD_BITS+2:0]  err,
    input  logic        [COORD_BITS-1:0]  major,
    input  logic        [COORD_BITS-1:0]  minor,
    input  logic        [COORD_BITS-1:0]  x,
    input  logic        [COORD_BITS-1:0]  y,
    output logic signed [COORD_BITS+2:0]  err_next,
    output logic        [COORD_BITS-1:0]  x_next,
    output logic        [COORD_BITS-1:0]  y_next
);

    localparam int EW = COORD_BITS + 3;

    logic                          minor_step;
    logic signed [EW-1:0]          minor2;
    logic signed [EW-1:0]          major2;
    logic        [COORD_BITS-1:0]  y_move;

    assign minor_step = (err > $signed(EW'(0)));
    assign minor2     = $signed({2'b00, minor, 1'b0});
    assign major2     = $signed({2'b00, major, 1'b0});
    assign err_next   = err + minor2 - (minor_step ? major2 : $signed(EW'(0)));
    assign y_move     = dir.down ? (y - COORD_BITS'(1)) : (y + COORD_BITS'(1));

    always_comb
    begin
        if (dir.steep)
        begin
            x_next = minor_step ? (x + COORD_BITS'(1)) : x;
            y_next = y_move;
        end
        else
        begin
            x_next = x + COORD_BITS'(1);
            y_next = minor_step ? y_move : y;
        end
    end

endmodule

// ----- sv/line_pixel_generator_unit.sv -----
// ----------------------------------------------------------------------------
// line_pixel_generator_unit
// Midpoint line rasteriser: one line request in, one pixel per result out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes a request of two endpoints and a
// colour. Endpoints are reordered so that x never decreases, then every pixel
// from start to end is sent on the output channel (out_valid/out_ready) with
// the colour, last_pixel marking the final one.
// Timing: the endpoints are ordered as the request is taken, then the set-up
// states follow (octant in ST_SETUP, then error start value in ST_INIT), then
// one pixel per cycle while out_ready allows, from a single shared step unit;
// a line has N = max(|dx|, |dy|) + 1 pixels, at most 2^COORD_BITS.
// in_ready is high only while no line is in progress; the next request can
// be taken while the final pixel still waits in the output register.
// A stall on out_ready holds the output register and freezes the walk.
// Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module line_pixel_generator_unit #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [COORD_BITS-1:0]          start_x,
    input  logic [COORD_BITS-1:0]          start_y,
    input  logic [COORD_BITS-1:0]          end_x,
    input  logic [COORD_BITS-1:0]          end_y,
    input  logic [lpg_pkg::COLOR_BITS-1:0] line_color,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [COORD_BITS-1:0]          pixel_x,
    output logic [COORD_BITS-1:0]          pixel_y,
    output logic [lpg_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                           last_pixel
);

    localparam int EW = COORD_BITS + 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_INIT,
        ST_RUN
    } state_t;

    state_t                           state_reg;
    logic        [COORD_BITS-1:0]     x0_reg;
    logic        [COORD_BITS-1:0]     y0_reg;
    logic        [COORD_BITS-1:0]     x1_reg;
    logic        [COORD_BITS-1:0]     y1_reg;
    logic        [lpg_pkg::COLOR_BITS-1:0] color_reg;
    lpg_pkg::dir_t                    dir_reg;
    logic        [COORD_BITS-1:0]     major_reg;
    logic        [COORD_BITS-1:0]     minor_reg;
    logic signed [EW-1:0]             err_reg;
    logic        [COORD_BITS-1:0]     cnt_reg;
    logic        [COORD_BITS-1:0]     xcur_reg;
    logic        [COORD_BITS-1:0]     ycur_reg;
    logic                             out_valid_reg;
    logic        [COORD_BITS-1:0]     pixel_x_reg;
    logic        [COORD_BITS-1:0]     pixel_y_reg;
    logic        [lpg_pkg::COLOR_BITS-1:0] pixel_color_reg;
    logic                             last_pixel_reg;

    logic                             accept;
    logic                             swap;
    logic                             out_free;
    logic        [COORD_BITS-1:0]     dx;
    logic                             ydown;
    logic        [COORD_BITS-1:0]     ady;
    logic                             steep;
    logic signed [EW-1:0]             err_next;
    logic        [COORD_BITS-1:0]     x_next;
    logic        [COORD_BITS-1:0]     y_next;

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign swap        = (start_x > end_x);
    assign out_free    = !out_valid_reg || out_ready;

    assign dx    = x1_reg - x0_reg;
    assign ydown = (y1_reg < y0_reg);
    assign ady   = ydown ? (y0_reg - y1_reg) : (y1_reg - y0_reg);
    // Exact diagonal going up counts as steep; going down it counts as shallow
    assign steep = ydown ? (ady > dx) : (ady >= dx);

    lpg_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .dir      (dir_reg),
        .err      (err_reg),
        .major    (major_reg),
        .minor    (minor_reg),
        .x        (xcur_reg),
        .y        (ycur_reg),
        .err_next (err_next),
        .x_next   (x_next),
        .y_next   (y_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            x0_reg          <= '0;
            y0_reg          <= '0;
            x1_reg          <= '0;
            y1_reg          <= '0;
            color_reg       <= '0;
            dir_reg         <= '0;
            major_reg       <= '0;
            minor_reg       <= '0;
            err_reg         <= '0;
            cnt_reg         <= '0;
            xcur_reg        <= '0;
            ycur_reg        <= '0;
            out_valid_reg   <= 1'b0;
            pixel_x_reg     <= '0;
            pixel_y_reg     <= '0;
            pixel_color_reg <= '0;
            last_pixel_reg  <= 1'b0;
        end
        else
        begin
            // while walking, the run state refills the output register itself
            if (out_valid_reg && out_ready && (state_reg != ST_RUN))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        // order endpoints so that x never decreases
                        x0_reg    <= swap ? end_x   : start_x;
                        y0_reg    <= swap ? end_y   : start_y;
                        x1_reg    <= swap ? start_x : end_x;
                        y1_reg    <= swap ? start_y : end_y;
                        color_reg <= line_color;
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    dir_reg.steep <= steep;
                    dir_reg.down  <= ydown;
                    major_reg     <= steep ? ady : dx;
                    minor_reg     <= steep ? dx : ady;
                    xcur_reg      <= x0_reg;
                    ycur_reg      <= y0_reg;
                    state_reg     <= ST_INIT;
                end
                ST_INIT:
                begin
                    err_reg   <= $signed({2'b00, minor_reg, 1'b0})
                               - $signed({3'b000, major_reg});
                    cnt_reg   <= major_reg;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    // advance only when the output register can take a pixel
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        pixel_x_reg     <= xcur_reg;
                        pixel_y_reg     <= ycur_reg;
                        pixel_color_reg <= color_reg;
                        last_pixel_reg  <= (cnt_reg == '0);
                        err_reg         <= err_next;
                        xcur_reg        <= x_next;
                        ycur_reg        <= y_next;
                        cnt_reg         <= cnt_reg - COORD_BITS'(1);
                        if (cnt_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_pixel_reg;

endmodule

// ----- sim/line_check_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_check_pkg
// Pixel prediction and scoreboard for the line pixel generator bench.
// ----------------------------------------------------------------------------
package line_check_pkg;

    localparam int COORD_W = lpg_pkg::COORD_BITS_DEF;
    localparam int COLOR_W = lpg_pkg::COLOR_BITS;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] colour;
        logic               last;
    } pixel_t;

    class line_scoreboard;
        pixel_t pixels_due[$];
        int     errors;
        int     lines_seen;
        int     pixels_seen;

        task report(input string msg);
            // keep the log short if the block is badly broken
            if (errors < 40)
                $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        // Walk the line with the midpoint error term and queue every pixel
        function void note_line(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                                input logic [COLOR_W-1:0] colour);
            int x0, y0, x1, y1, tmp, dx, dy, d, n, x, y;
            lpg_pkg::dir_t dir;
            pixel_t px;
            x0 = int'(sx);
            y0 = int'(sy);
            x1 = int'(ex);
            y1 = int'(ey);
            if (x0 > x1)
            begin
                tmp = x0; x0 = x1; x1 = tmp;
                tmp = y0; y0 = y1; y1 = tmp;
            end
            dx = x1 - x0;
            dy = y1 - y0;
            dir.down  = (dy < 0);
            dir.steep = dir.down ? (-dy > dx) : (dy >= dx);
            n = (dir.steep ? (dir.down ? -dy : dy) : dx) + 1;
            if (!dir.steep && !dir.down)
                d = 2 * dy - dx;
            else if (dir.steep && !dir.down)
                d = dy - 2 * dx;
            else if (dir.steep)
                d = dy + 2 * dx;
            else
                d = 2 * dy + dx;
            x = x0;
            y = y0;
            for (int i = 0; i < n; i++)
            begin
                px.x      = x[COORD_W-1:0];
                px.y      = y[COORD_W-1:0];
                px.colour = colour;
                px.last   = (i == n - 1);
                pixels_due.push_back(px);
                if (!dir.steep && !dir.down)
                begin
                    if (d > 0)
                    begin
                        y++;
                        d -= 2 * dx;
                    end
                    x++;
                    d += 2 * dy;
                end
                else if (dir.steep && !dir.down)
                begin
                    if (d < 0)
                    begin
                        x++;
                        d += 2 * dy;
                    end
                    y++;
                    d -= 2 * dx;
                end
                else if (dir.steep)
                begin
                    if (d > 0)
                    begin
                        x++;
                        d += 2 * dy;
                    end
                    y--;
                    d += 2 * dx;
                end
                else
                begin
                    if (d < 0)
                    begin
                        y--;
                        d += 2 * dx;
                    end
                    x++;
                    d += 2 * dy;
                end
            end
            lines_seen++;
        endfunction

        task check_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                         input logic [COLOR_W-1:0] colour, input logic last);
            pixel_t want;
            pixels_seen++;
            if (pixels_due.size() == 0)
            begin
                report($sformatf("pixel (%0d,%0d) with no line outstanding", x, y));
                return;
            end
            want = pixels_due.pop_front();
            if (x !== want.x)
                report($sformatf("pixel_x %0d, want %0d", x, want.x));
            if (y !== want.y)
                report($sformatf("pixel_y %0d, want %0d", y, want.y));
            if (colour !== want.colour)
                report($sformatf("pixel_color %06h, want %06h", colour, want.colour));
            if (last !== want.last)
                report($sformatf("last_pixel %0b, want %0b at (%0d,%0d)",
                                 last, want.last, want.x, want.y));
        endtask

        task check_drained();
            if (pixels_due.size() != 0)
                report($sformatf("%0d pixels never emitted", pixels_due.size()));
        endtask
    endclass

endpackage

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Line pixel generator: directed and random line requests, checked per pixel.
// ----------------------------------------------------------------------------
// Each accepted request is walked by the scoreboard, which queues the pixels
// in drawing order; every pixel leaving the block is compared field by field.
// Flow control: two phases with random idling on both sides, then full rate.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RAND_PER_PHASE = 64;
    localparam int COORD_W        = line_check_pkg::COORD_W;
    localparam int COLOR_W        = line_check_pkg::COLOR_W;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [COORD_W-1:0] start_x = '0;
    logic [COORD_W-1:0] start_y = '0;
    logic [COORD_W-1:0] end_x = '0;
    logic [COORD_W-1:0] end_y = '0;
    logic [COLOR_W-1:0] line_color = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;

    int tx_idle_pct = 30;
    int rx_idle_pct = 61;

    line_check_pkg::line_scoreboard sb = new();

    line_pixel_generator_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .line_color (line_color),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_color(pixel_color),
        .last_pixel (last_pixel)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_pixel(pixel_x, pixel_y, pixel_color, last_pixel);

    // Present one request and hold it until the block takes it
    task automatic send_line(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                             input logic [COLOR_W-1:0] colour);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_x    <= sx;
        start_y    <= sy;
        end_x      <= ex;
        end_y      <= ey;
        line_color <= colour;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_line(sx, sy, ex, ey, colour);
    endtask

    // Hold off new requests until every queued pixel has come out
    task automatic drain_pixels();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pixels_due.size() != 0);
    endtask

    function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] base);
        int c;
        c = int'(base) + int'($urandom_range(6)) - 3;
        if (c < 0)
            c = 0;
        if (c > (1 << COORD_W) - 1)
            c = (1 << COORD_W) - 1;
        return c[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] edge_coord();
        case ($urandom_range(3))
            0: return '0;
            1: return COORD_W'(1);
            2: return COORD_W'((1 << COORD_W) - 2);
            default: return COORD_W'((1 << COORD_W) - 1);
        endcase
    endfunction

    task automatic send_random_line();
        logic [COORD_W-1:0] sx, sy, ex, ey;
        logic [COLOR_W-1:0] colour;
        sx     = COORD_W'($urandom_range((1 << COORD_W) - 1));
        sy     = COORD_W'($urandom_range((1 << COORD_W) - 1));
        ex     = COORD_W'($urandom_range((1 << COORD_W) - 1));
        ey     = COORD_W'($urandom_range((1 << COORD_W) - 1));
        colour = COLOR_W'($urandom_range((1 << COLOR_W) - 1));
        case ($urandom_range(3))
            2:
            begin
                // short lines keep the input side busy
                ex = near_coord(sx);
                ey = near_coord(sy);
            end
            3:
            begin
                sx = edge_coord();
                sy = edge_coord();
                ex = edge_coord();
                ey = edge_coord();
            end
            default: ;
        endcase
        send_line(sx, sy, ex, ey, colour);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single points, axis lines, diagonals, every octant, swapped ends
        send_line(6'd0, 6'd0, 6'd0, 6'd0, 24'h000000);
        send_line(6'd63, 6'd63, 6'd63, 6'd63, 24'hFFFFFF);
        send_line(6'd0, 6'd0, 6'd63, 6'd0, 24'hAAAAAA);
        send_line(6'd63, 6'd5, 6'd0, 6'd5, 24'h555555);
        send_line(6'd7, 6'd0, 6'd7, 6'd63, 24'hFFFFFF);
        send_line(6'd9, 6'd63, 6'd9, 6'd0, 24'h000000);
        send_line(6'd0, 6'd0, 6'd63, 6'd63, 24'h123456);
        send_line(6'd0, 6'd63, 6'd63, 6'd0, 24'hFEDCBA);
        send_line(6'd63, 6'd63, 6'd0, 6'd0, 24'hAAAAAA);
        send_line(6'd0, 6'd0, 6'd63, 6'd20, 24'h555555);
        send_line(6'd0, 6'd0, 6'd20, 6'd63, 24'hFF0000);
        send_line(6'd0, 6'd63, 6'd63, 6'd40, 24'h00FF00);
        send_line(6'd0, 6'd63, 6'd20, 6'd0, 24'h0000FF);
        send_line(6'd50, 6'd10, 6'd3, 6'd40, 24'h808080);
        send_line(6'd40, 6'd2, 6'd30, 6'd60, 24'h7F7F7F);
        send_line(6'd1, 6'd1, 6'd2, 6'd2, 24'h010203);
        send_line(6'd5, 6'd5, 6'd6, 6'd5, 24'hFFFFFF);
        send_line(6'd0, 6'd0, 6'd63, 6'd62, 24'h000001);
        send_line(6'd0, 6'd0, 6'd62, 6'd63, 24'h800000);
        send_line(6'd63, 6'd0, 6'd0, 6'd1, 24'hAAAAAA);
        drain_pixels();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin tx_idle_pct = 30; rx_idle_pct = 61; end
                1: begin tx_idle_pct = 61; rx_idle_pct = 30; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                send_random_line();
                if ($urandom_range(19) == 0)
                    drain_pixels();
            end
            drain_pixels();
        end

        repeat (16) @(posedge clk);
        sb.check_drained();
        $display("Covered %0d line requests giving %0d pixels, all octants and swapped ends,",
                 sb.lines_seen, sb.pixels_seen);
        $display("under sender idling, receiver stalls and full-rate flow.");
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timeout with %0d pixels still due", sb.pixels_due.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/lpg_pkg.sv
sv/lpg_step.sv
sv/line_pixel_generator_unit.sv
sim/line_check_pkg.sv
sim/testbench.sv
